### hw/rtl/wavetable_oscillator_lookup_defines.svh
// Assertion macros shared by the wavetable oscillator RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef WAVETABLE_OSCILLATOR_LOOKUP_DEFINES_SVH
`define WAVETABLE_OSCILLATOR_LOOKUP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define WOL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication with a fixed delay between cause and effect.
`define WOL_ASSERT_LAT(label, ante, n, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error(msg);

`endif

### hw/rtl/wol_pkg.sv
// Package for the wavetable oscillator: sizes, waveform codes, fixed-point
// constants and small shared functions. Depends on nothing.
`timescale 1ns / 1ps

package wol_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
    localparam int PHASE_BITS    = 32;
    localparam int SAMPLE_BITS   = 16;
    localparam int ROUND_SH      = 31 - SAMPLE_BITS;

    // Sine pipeline depth and total start-to-result latency.
    localparam int SIN_LAT = 9;
    localparam int LATENCY = SIN_LAT + 3;

    localparam logic [31:0] PHASE_KEEP = ~((32'd1 << (32 - PHASE_BITS)) - 32'd1);

    // Internal values are Q30 held in 34-bit signed words.
    localparam logic signed [33:0] QONE   = 34'sd1073741824;
    localparam logic [30:0]        QONE31 = 31'h4000_0000;
    localparam logic [31:0]        QONE32 = 32'h4000_0000;

    localparam logic [31:0] C1  = 32'd1686629713;
    localparam logic [31:0] C3  = 32'd693598669;
    localparam logic [31:0] C5  = 32'd85569304;
    localparam logic [31:0] C7  = 32'd5026995;
    localparam logic [31:0] C9  = 32'd172272;
    localparam logic [31:0] C11 = 32'd3864;
    localparam logic [31:0] C13 = 32'd61;

    // Reciprocals for exact division of 32-bit values by 3, 5 and 10.
    localparam logic [31:0] RECIP_3  = 32'hAAAA_AAAB;
    localparam logic [31:0] RECIP_10 = 32'hCCCC_CCCD;

    localparam logic [15:0] PW_MIN = 16'd6554;
    localparam logic [15:0] PW_MAX = 16'd58982;

    // Trapezoid breakpoints at 0.15 and 0.65 of a cycle.
    localparam logic [31:0] TRAP_RISE_END = 32'd644245095;
    localparam logic [31:0] TRAP_FALL_END = 32'd2791728743;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef enum logic [3:0] {
        CMD_SINE     = 4'd0,
        CMD_SAW      = 4'd1,
        CMD_SQUARE   = 4'd2,
        CMD_TRIANGLE = 4'd3,
        CMD_PULSE    = 4'd4,
        CMD_DSINE    = 4'd5,
        CMD_HSINE    = 4'd6,
        CMD_RSAW     = 4'd7,
        CMD_RTRI     = 4'd8,
        CMD_TRAP     = 4'd9
    } cmd_t;

    typedef struct packed {
        logic [3:0]  cmd;
        logic [31:0] ph;
        logic [15:0] pw;
    } side_t;

    // Horner coefficients from the highest remaining order down.
    function automatic logic [31:0] horner_coef(input int k);
        logic [31:0] c;
        case (k)
            0:       c = C11;
            1:       c = C9;
            2:       c = C7;
            3:       c = C5;
            4:       c = C3;
            default: c = C1;
        endcase
        return c;
    endfunction

    function automatic logic signed [33:0] tri_of(input logic [31:0] ph);
        logic signed [33:0] p;
        logic signed [33:0] r;
        p = $signed({2'b00, ph});
        if (ph < 32'h4000_0000) begin
            r = p;
        end else if (ph < 32'hC000_0000) begin
            r = 34'sh0_8000_0000 - p;
        end else begin
            r = p - 34'sh1_0000_0000;
        end
        return r;
    endfunction

endpackage

### hw/rtl/wol_sin.sv
// Pipelined sine unit: quarter-wave odd polynomial in Q30, Horner form,
// at most one multiply per stage. Depends on wol_pkg.
`timescale 1ns / 1ps

module wol_sin
    import wol_pkg::*;
(
    input  logic               clk,
    input  logic [31:0]        angle,
    output logic signed [31:0] sine
);

    logic [30:0]        t_next;
    logic [30:0]        t_reg   [1:8];
    logic               neg_reg [1:8];
    logic [30:0]        t2_reg  [2:7];
    logic [30:0]        acc_reg [3:8];
    logic [61:0]        sq_full;
    logic [61:0]        fin_prod;
    logic [31:0]        mag;
    logic signed [31:0] sine_next;
    logic signed [31:0] sine_reg;

    // Odd quarters run the polynomial on the mirrored argument.
    assign t_next  = angle[30] ? (QONE31 - {1'b0, angle[29:0]}) : {1'b0, angle[29:0]};
    assign sq_full = t_reg[1] * t_reg[1];

    always_ff @(posedge clk)
    begin
        t_reg[1]   <= t_next;
        neg_reg[1] <= angle[31];
        t2_reg[2]  <= sq_full[60:30];
        for (int s = 2; s <= 8; s++)
        begin
            t_reg[s]   <= t_reg[s-1];
            neg_reg[s] <= neg_reg[s-1];
        end
        for (int s = 3; s <= 7; s++)
        begin
            t2_reg[s] <= t2_reg[s-1];
        end
    end

    for (genvar s = 3; s <= 8; s++)
    begin : g_horner
        logic [30:0] prev;
        logic [61:0] prod;
        logic [31:0] acc_next;
        if (s == 3)
        begin : g_first
            assign prev = C13[30:0];
        end
        else
        begin : g_rest
            assign prev = acc_reg[s-1];
        end
        assign prod     = prev * t2_reg[s-1];
        assign acc_next = horner_coef(s - 3) - prod[61:30];
        always_ff @(posedge clk)
        begin
            acc_reg[s] <= acc_next[30:0];
        end
    end

    assign fin_prod  = acc_reg[8] * t_reg[8];
    assign mag       = (fin_prod[61:30] > QONE32) ? QONE32 : fin_prod[61:30];
    assign sine_next = neg_reg[8] ? -$signed(mag) : $signed(mag);

    always_ff @(posedge clk)
    begin
        sine_reg <= sine_next;
    end

    assign sine = sine_reg;

endmodule

### hw/rtl/wol_shape.sv
// Waveform shaping: table interpolation, reciprocal divides, clamps, and
// rounding to the output code in two register stages. Depends on wol_pkg.
`timescale 1ns / 1ps

module wol_shape
    import wol_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  side_t                         side,
    input  logic signed [31:0]            s0,
    input  logic signed [31:0]            s1,
    output logic                          done,
    output logic signed [SAMPLE_BITS-1:0] sample
);

    typedef enum logic [1:0] {
        REG_RISE = 2'd0,
        REG_HIGH = 2'd1,
        REG_FALL = 2'd2,
        REG_LOW  = 2'd3
    } trap_reg_t;

    logic [IDX_BITS-1:0] i0;
    logic [IDX_BITS-1:0] i1;
    logic [29:0]         frac;
    logic signed [33:0]  s0x;
    logic signed [33:0]  s1x;
    logic signed [33:0]  e0;
    logic signed [33:0]  e1;
    logic signed [33:0]  diff;
    logic signed [33:0]  dsum;
    logic [31:0]         mop;
    logic [31:0]         kop;
    logic [15:0]         wc;
    logic signed [33:0]  base_next;
    logic                neg_next;
    logic signed [63:0]  ip_next;
    logic [63:0]         mk_next;
    trap_reg_t           region_next;

    logic                vx_reg;
    logic [3:0]          cmd_reg;
    logic signed [33:0]  base_reg;
    logic                neg_reg;
    logic signed [63:0]  ip_reg;
    logic [63:0]         mk_reg;
    trap_reg_t           region_reg;
    logic [30:0]         tp_reg;

    logic signed [33:0]  q3;
    logic signed [33:0]  q34;
    logic signed [33:0]  q35;
    logic signed [33:0]  tp3;
    logic signed [33:0]  v;
    logic signed [33:0]  rnd;
    logic [SAMPLE_BITS-1:0] sample_next;
    logic                done_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;

    function automatic logic signed [33:0] entry(input logic [3:0] c,
                                                 input logic [IDX_BITS-1:0] i,
                                                 input logic signed [33:0] s);
        logic signed [33:0] r;
        case (c)
            CMD_SINE:   r = s;
            CMD_SAW:    r = $signed({2'b00, 32'(i) << (31 - IDX_BITS)}) - QONE;
            CMD_SQUARE: r = i[IDX_BITS-1] ? -QONE : QONE;
            default:    r = tri_of(32'(i) << (32 - IDX_BITS));
        endcase
        return r;
    endfunction

    function automatic logic signed [33:0] clamp1(input logic signed [33:0] x);
        logic signed [33:0] r;
        if (x > QONE) begin
            r = QONE;
        end else if (x < -QONE) begin
            r = -QONE;
        end else begin
            r = x;
        end
        return r;
    endfunction

    assign i0   = side.ph[31 -: IDX_BITS];
    assign i1   = i0 + 1'b1;
    assign frac = {side.ph[31-IDX_BITS:0], {(IDX_BITS-2){1'b0}}};
    assign s0x  = 34'(s0);
    assign s1x  = 34'(s1);
    assign e0   = entry(side.cmd, i0, s0x);
    assign e1   = entry(side.cmd, i1, s1x);
    assign diff = e1 - e0;
    assign wc   = (side.pw < PW_MIN) ? PW_MIN : ((side.pw > PW_MAX) ? PW_MAX : side.pw);
    assign ip_next = diff * $signed({1'b0, frac});

    always_comb
    begin
        base_next = '0;
        neg_next  = 1'b0;
        dsum      = '0;
        mop       = '0;
        kop       = RECIP_3;
        case (side.cmd) inside
            CMD_SINE, CMD_SAW, CMD_SQUARE, CMD_TRIANGLE:
            begin
                base_next = e0;
            end
            CMD_PULSE:
            begin
                base_next = (side.ph < {wc, 16'h0000}) ? QONE : -QONE;
            end
            CMD_DSINE:
            begin
                dsum     = (s0x <<< 1) + s1x;
                neg_next = dsum[33];
                mop      = dsum[33] ? 32'(-dsum) : dsum[31:0];
            end
            CMD_HSINE:
            begin
                base_next = (s0x > 34'sd0) ? s0x : 34'sd0;
            end
            CMD_RSAW:
            begin
                dsum      = s0x + (s0x <<< 1);
                neg_next  = dsum[33];
                mop       = dsum[33] ? 32'(-dsum) : dsum[31:0];
                kop       = RECIP_10;
                base_next = $signed({3'b000, side.ph[31:1]}) - QONE;
            end
            CMD_RTRI:
            begin
                neg_next  = s0x[33];
                mop       = s0x[33] ? 32'(-s0x) : s0x[31:0];
                kop       = RECIP_10;
                base_next = tri_of(side.ph);
            end
            CMD_TRAP:
            begin
                mop = {1'b0, side.ph[30:0]};
            end
            default:
            begin
                base_next = '0;
            end
        endcase
    end

    assign mk_next = mop * kop;

    always_comb
    begin
        if (side.ph < TRAP_RISE_END) begin
            region_next = REG_RISE;
        end else if (!side.ph[31]) begin
            region_next = REG_HIGH;
        end else if (side.ph < TRAP_FALL_END) begin
            region_next = REG_FALL;
        end else begin
            region_next = REG_LOW;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vx_reg   <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            vx_reg   <= in_valid;
            done_reg <= vx_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= side.cmd;
        base_reg   <= base_next;
        neg_reg    <= neg_next;
        ip_reg     <= ip_next;
        mk_reg     <= mk_next;
        region_reg <= region_next;
        tp_reg     <= side.ph[30:0];
        sample_reg <= sample_next;
    end

    assign q3  = $signed({3'b000, mk_reg[63:33]});
    assign q34 = $signed({4'b0000, mk_reg[63:34]});
    assign q35 = $signed({5'b00000, mk_reg[63:35]});
    assign tp3 = $signed(34'(tp_reg) + (34'(tp_reg) << 1)) + q3;

    always_comb
    begin
        case (cmd_reg) inside
            CMD_SINE, CMD_SAW, CMD_SQUARE, CMD_TRIANGLE:
            begin
                v = base_reg + $signed(ip_reg[63:30]);
            end
            CMD_DSINE:
            begin
                v = neg_reg ? -q3 : q3;
            end
            CMD_RSAW:
            begin
                v = clamp1(base_reg + (neg_reg ? -q35 : q35));
            end
            CMD_RTRI:
            begin
                v = clamp1(base_reg + (neg_reg ? -q34 : q34));
            end
            CMD_TRAP:
            begin
                case (region_reg)
                    REG_RISE: v = tp3 - QONE;
                    REG_HIGH: v = QONE;
                    REG_FALL: v = QONE - tp3;
                    default:  v = -QONE;
                endcase
            end
            default:
            begin
                v = base_reg;
            end
        endcase
    end

    // Round half up to the output grid, then saturate both ways.
    assign rnd = (v + (34'sd1 <<< (ROUND_SH - 1))) >>> ROUND_SH;

    always_comb
    begin
        if (rnd > 34'(SAMPLE_MAX)) begin
            sample_next = SAMPLE_MAX;
        end else if (rnd < 34'(SAMPLE_MIN)) begin
            sample_next = SAMPLE_MIN;
        end else begin
            sample_next = rnd[SAMPLE_BITS-1:0];
        end
    end

    assign done   = done_reg;
    assign sample = $signed(sample_reg);

endmodule

### hw/rtl/wavetable_oscillator_lookup.sv
// Wavetable oscillator lookup: one signed sample for each waveform select,
// phase and pulse width. A transaction taken on start runs through the input
// register, the sine pipeline and the shaping stages until done is high; one
// transaction can be taken every clock cycle. The sine pipeline sets the
// depth: one register per polynomial multiply, two sine units in parallel.
//
// Drive cmd, phase and pulse_width with start high; the transaction is taken
// at that rising edge because busy is always low. After the sine pipeline and
// the shaping stages, done is high for one cycle with sample valid in that
// cycle. Results come out in the order taken. The receiver cannot stall, so
// nothing is held back. Reset clears every valid bit: a transaction in flight
// at reset is dropped and done stays low until new transactions work through.
// Depends on wol_pkg, wol_sin, wol_shape and the assertion macro header.
`timescale 1ns / 1ps
`include "wavetable_oscillator_lookup_defines.svh"

module wavetable_oscillator_lookup
    import wol_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [3:0]                    cmd,
    input  logic [31:0]                   phase,
    input  logic [15:0]                   pulse_width,
    output logic                          busy,
    output logic                          done,
    output logic signed [SAMPLE_BITS-1:0] sample
);

    logic                valid_reg [1:SIN_LAT+1];
    side_t               side_reg  [1:SIN_LAT+1];
    side_t               side_next;
    logic [31:0]         ph;
    logic [IDX_BITS-1:0] idx0;
    logic [IDX_BITS-1:0] idx1;
    logic [31:0]         angle0;
    logic [31:0]         angle1;
    logic signed [31:0]  sin0;
    logic signed [31:0]  sin1;

    assign busy      = 1'b0;
    assign side_next = '{cmd: cmd, ph: phase & PHASE_KEEP, pw: pulse_width};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int s = 1; s <= SIN_LAT + 1; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
        end else begin
            valid_reg[1] <= start && !busy;
            for (int s = 2; s <= SIN_LAT + 1; s++)
            begin
                valid_reg[s] <= valid_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[1] <= side_next;
        for (int s = 2; s <= SIN_LAT + 1; s++)
        begin
            side_reg[s] <= side_reg[s-1];
        end
    end

    // Table sines read both neighbors; double sine needs the octave as well.
    assign ph   = side_reg[1].ph;
    assign idx0 = ph[31 -: IDX_BITS];
    assign idx1 = idx0 + 1'b1;

    always_comb
    begin
        angle0 = '0;
        angle1 = '0;
        case (side_reg[1].cmd)
            CMD_SINE:
            begin
                angle0 = 32'(idx0) << (32 - IDX_BITS);
                angle1 = 32'(idx1) << (32 - IDX_BITS);
            end
            CMD_DSINE:
            begin
                angle0 = ph;
                angle1 = ph << 1;
            end
            CMD_HSINE: angle0 = ph;
            CMD_RSAW:  angle0 = ph + (ph << 1);
            CMD_RTRI:  angle0 = ph + (ph << 2);
            default:   angle0 = '0;
        endcase
    end

    wol_sin u_sin0 (
        .clk   (clk),
        .angle (angle0),
        .sine  (sin0)
    );

    wol_sin u_sin1 (
        .clk   (clk),
        .angle (angle1),
        .sine  (sin1)
    );

    wol_shape u_shape (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (valid_reg[SIN_LAT+1]),
        .side     (side_reg[SIN_LAT+1]),
        .s0       (sin0),
        .s1       (sin1),
        .done     (done),
        .sample   (sample)
    );

    `WOL_ASSERT_LAT(a_latency, start && !busy, LATENCY, done,
        "result strobe missing after latency")
    `WOL_ASSERT_IMP(a_pulse_rails, done && $past(start && cmd == CMD_PULSE, LATENCY),
        sample == SAMPLE_MAX || sample == SAMPLE_MIN, "pulse sample off the rails")
    `WOL_ASSERT_IMP(a_unused_zero, done && $past(start && cmd > CMD_TRAP, LATENCY),
        sample == '0, "unused select gave nonzero sample")
    `WOL_ASSERT_IMP(a_hsine_pos, done && $past(start && cmd == CMD_HSINE, LATENCY),
        !sample[SAMPLE_BITS-1], "half sine went negative")

endmodule
